/* src/pcs_pkg.sv */
// shared constants and types for the percentile contrast stretch
`default_nettype none
package pcs_pkg;
    localparam int SAMPLE_BITS  = 16;
    localparam int MAX_CHANNELS = 4;
    localparam int COUNT_BITS   = 32;
    localparam int CHAN_BITS    = 2;
    localparam int NBINS        = 1 << SAMPLE_BITS;
    localparam int ADDR_BITS    = CHAN_BITS + SAMPLE_BITS;
    localparam int DEPTH        = MAX_CHANNELS * NBINS;
    localparam int QDEPTH       = 4;
    localparam int QPTR_BITS    = 2;
    localparam int QUO_BITS     = 8;

    localparam logic REQ_COLLECT = 1'b0;
    localparam logic REQ_MAP     = 1'b1;

    localparam logic [1:0] CFG_CHANNEL_COUNT = 2'd0;
    localparam logic [1:0] CFG_RATIO_LOW     = 2'd1;
    localparam logic [1:0] CFG_RATIO_HIGH    = 2'd2;

    localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

    typedef struct packed {
        logic                   req_type;
        logic [CHAN_BITS-1:0]   chan;
        logic [SAMPLE_BITS-1:0] sample;
        logic                   last;
        logic                   active;
    } pcs_item_t;
endpackage
`default_nettype wire

/* src/pcs_ram.sv */
// generic single-port ram with registered read
`default_nettype none
module pcs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule
`default_nettype wire

/* src/pcs_front.sv */
// input stage: classifies requests and queues them for the back end
`default_nettype none
module pcs_front import pcs_pkg::*; (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic                   req_type,
    input  wire logic [CHAN_BITS-1:0]   chan,
    input  wire logic [SAMPLE_BITS-1:0] sample,
    input  wire logic                   last,
    input  wire logic [2:0]             channel_count,
    output logic                        q_valid,
    output pcs_item_t                   q_item,
    input  wire logic                   q_pop
);
    pcs_item_t              q_mem [QDEPTH];
    logic [QPTR_BITS-1:0]   wr_reg, wr_next, rd_reg, rd_next;
    logic [QPTR_BITS:0]     cnt_reg, cnt_next;
    logic [2:0]             nch;
    pcs_item_t              item;
    logic                   push;

    always_comb begin
        if (channel_count == 3'd0) nch = 3'd1;
        else if (channel_count > 3'(MAX_CHANNELS)) nch = 3'(MAX_CHANNELS);
        else nch = channel_count;
        item.req_type = req_type;
        item.chan     = chan;
        item.sample   = sample;
        item.last     = last;
        item.active   = {1'b0, chan} < nch;
    end

    assign s_tready = cnt_reg != (QPTR_BITS+1)'(QDEPTH);
    assign push     = s_tvalid && s_tready;
    assign q_valid  = cnt_reg != '0;
    assign q_item   = q_mem[rd_reg];
    assign wr_next  = push ? wr_reg + 1'b1 : wr_reg;
    assign rd_next  = q_pop ? rd_reg + 1'b1 : rd_reg;
    assign cnt_next = cnt_reg + (QPTR_BITS+1)'(push) - (QPTR_BITS+1)'(q_pop);

    always_ff @(posedge aclk) begin
        if (push) begin
            q_mem[wr_reg] <= item;
        end
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end
endmodule
`default_nettype wire

/* src/pcs_back.sv */
// execution: histogram update, bound search, sample mapping, clearing
`default_nettype none
module pcs_back import pcs_pkg::*; (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   q_valid,
    input  wire pcs_item_t              q_item,
    output logic                        q_pop,
    input  wire logic [2:0]             channel_count,
    input  wire logic [15:0]            ratio_low,
    input  wire logic [15:0]            ratio_high,
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic [7:0]                  pixel_out,
    output logic [CHAN_BITS-1:0]        chan_out,
    output logic [15:0]                 low_used,
    output logic [15:0]                 high_used,
    output logic                        last_out
);
    typedef enum logic [8:0] {
        ST_CLEAR  = 9'b000000001,
        ST_IDLE   = 9'b000000010,
        ST_RD     = 9'b000000100,
        ST_WR     = 9'b000001000,
        ST_THR    = 9'b000010000,
        ST_SEARCH = 9'b000100000,
        ST_SWAIT  = 9'b001000000,
        ST_DIV    = 9'b010000000,
        ST_OUT    = 9'b100000000
    } state_t;

    state_t                 state_reg, state_next;
    pcs_item_t              cur_reg;
    logic [COUNT_BITS-1:0]  total_reg;
    logic [15:0]            lo_reg [MAX_CHANNELS];
    logic [15:0]            hi_reg [MAX_CHANNELS];
    logic [ADDR_BITS-1:0]   addr_reg;
    logic [CHAN_BITS:0]     sc_reg;
    logic                   sdir_reg;
    logic [SAMPLE_BITS-1:0] bin_reg;
    logic [COUNT_BITS-1:0]  run_reg;
    logic [COUNT_BITS+15:0] thr_l_reg, thr_h_reg;
    logic                   m_tvalid_reg;
    logic [7:0]             pixel_reg;
    logic [CHAN_BITS-1:0]   chan_reg;
    logic [15:0]            low_reg, high_reg;
    logic                   last_reg;
    logic [2:0]             nch;
    logic                   we;
    logic [ADDR_BITS-1:0]   ram_addr;
    logic [COUNT_BITS-1:0]  wdata, rdata;
    logic [COUNT_BITS:0]    sum;
    logic [COUNT_BITS-1:0]  run_next;
    logic                   hit_lo, hit_hi, more_chan;
    logic [15:0]            bnd_lo, bnd_hi, vv;
    logic [15:0]            q_diff, q_span;
    logic [23:0]            rem_reg;
    logic [22:0]            den_reg;
    logic [QUO_BITS-1:0]    quo_reg;
    logic [3:0]             dcnt_reg;
    logic [24:0]            trial;

    assign nch = (channel_count == 3'd0) ? 3'd1 :
                 (channel_count > 3'(MAX_CHANNELS)) ? 3'(MAX_CHANNELS) : channel_count;

    pcs_ram #(.WIDTH(COUNT_BITS), .DEPTH(DEPTH)) u_hist (
        .aclk(aclk), .we(we), .addr(ram_addr), .wdata(wdata), .rdata(rdata)
    );

    assign ram_addr = (state_reg == ST_SEARCH || state_reg == ST_SWAIT)
                      ? {sc_reg[CHAN_BITS-1:0], bin_reg} : addr_reg;
    assign we       = (state_reg == ST_CLEAR) || (state_reg == ST_WR);
    assign wdata    = (state_reg == ST_CLEAR) ? '0 :
                      (rdata == CNT_MAX) ? rdata : rdata + 1'b1;
    assign sum      = {1'b0, run_reg} + {1'b0, rdata};
    assign run_next = sum[COUNT_BITS] ? CNT_MAX : sum[COUNT_BITS-1:0];
    assign hit_lo   = {run_next, 16'd0} > thr_l_reg;
    assign hit_hi   = {run_next, 16'd0} > thr_h_reg;
    assign more_chan = (sc_reg + 1'b1) < nch;
    // a request is popped only in idle, and only when the result register is empty or its result is being taken
    assign q_pop    = (state_reg == ST_IDLE) && q_valid && (!m_tvalid_reg || m_tready);

    assign bnd_lo = lo_reg[cur_reg.chan];
    assign bnd_hi = hi_reg[cur_reg.chan];
    assign vv     = cur_reg.sample;
    // divider operands taken straight from the queue head
    assign q_diff = q_item.sample - lo_reg[q_item.chan];
    assign q_span = hi_reg[q_item.chan] - lo_reg[q_item.chan];
    assign trial  = {1'b0, rem_reg} - {2'b00, den_reg};

    assign m_tvalid  = m_tvalid_reg;
    assign pixel_out = pixel_reg;
    assign chan_out  = chan_reg;
    assign low_used  = low_reg;
    assign high_used = high_reg;
    assign last_out  = last_reg;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:  if (addr_reg == ADDR_BITS'(DEPTH-1)) state_next = ST_IDLE;
            ST_IDLE: begin
                if (q_pop) begin
                    if (q_item.req_type == REQ_MAP) state_next = ST_DIV;
                    else if (q_item.active) state_next = ST_RD;
                    else if (q_item.last) state_next = ST_THR;
                end
            end
            ST_RD:     state_next = ST_WR;
            ST_WR:     state_next = cur_reg.last ? ST_THR : ST_IDLE;
            ST_THR:    state_next = ST_SEARCH;
            ST_SEARCH: state_next = ST_SWAIT;
            ST_SWAIT: begin
                if (sdir_reg && (hit_hi || bin_reg == '0) && !more_chan)
                    state_next = ST_IDLE;
                else
                    state_next = ST_SEARCH;
            end
            ST_DIV:    if (dcnt_reg == 4'd1) state_next = ST_OUT;
            ST_OUT:    state_next = cur_reg.last ? ST_CLEAR : ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            addr_reg     <= '0;
            total_reg    <= '0;
            m_tvalid_reg <= 1'b0;
            for (int i = 0; i < MAX_CHANNELS; i++) begin
                lo_reg[i] <= '0;
                hi_reg[i] <= '0;
            end
        end else begin
            state_reg <= state_next;
            if (m_tvalid_reg && m_tready) m_tvalid_reg <= 1'b0;
            unique case (state_reg)
                ST_CLEAR: addr_reg <= addr_reg + 1'b1;
                ST_IDLE: if (q_pop) begin
                    cur_reg  <= q_item;
                    addr_reg <= {q_item.chan, q_item.sample[SAMPLE_BITS-1:0]};
                    // 255*(v-lo) against (hi-lo) aligned for eight quotient bits
                    rem_reg  <= {q_diff, 8'd0} - {8'd0, q_diff};
                    den_reg  <= {q_span, 7'd0};
                    quo_reg  <= '0;
                    dcnt_reg <= 4'd8;
                end
                ST_RD: ;
                ST_WR: if (cur_reg.chan == '0 && total_reg != CNT_MAX)
                    total_reg <= total_reg + 1'b1;
                ST_THR: begin
                    thr_l_reg <= {16'd0, total_reg} * {32'd0, ratio_low};
                    thr_h_reg <= {16'd0, total_reg} * {32'd0, ratio_high};
                    for (int i = 0; i < MAX_CHANNELS; i++) begin
                        lo_reg[i] <= '0;
                        hi_reg[i] <= '0;
                    end
                    sc_reg   <= '0;
                    sdir_reg <= 1'b0;
                    bin_reg  <= '0;
                    run_reg  <= '0;
                end
                ST_SEARCH: ;
                // each bin is read in ST_SEARCH and tested here, upwards for the low bound then downwards
                ST_SWAIT: begin
                    if (!sdir_reg) begin
                        if (hit_lo || bin_reg == SAMPLE_BITS'(NBINS-1)) begin
                            if (hit_lo)
                                lo_reg[sc_reg[CHAN_BITS-1:0]] <=
                                    (bin_reg != '0) ? bin_reg - 1'b1 : '0;
                            sdir_reg <= 1'b1;
                            bin_reg  <= SAMPLE_BITS'(NBINS-1);
                            run_reg  <= '0;
                        end else begin
                            bin_reg <= bin_reg + 1'b1;
                            run_reg <= run_next;
                        end
                    end else begin
                        if (hit_hi || bin_reg == '0) begin
                            if (hit_hi)
                                hi_reg[sc_reg[CHAN_BITS-1:0]] <=
                                    (bin_reg != SAMPLE_BITS'(NBINS-1)) ? bin_reg + 1'b1 : bin_reg;
                            sdir_reg <= 1'b0;
                            bin_reg  <= '0;
                            run_reg  <= '0;
                            sc_reg   <= sc_reg + 1'b1;
                        end else begin
                            bin_reg <= bin_reg - 1'b1;
                            run_reg <= run_next;
                        end
                    end
                end
                ST_DIV: begin
                    if (!trial[24]) begin
                        rem_reg <= trial[23:0];
                        quo_reg <= {quo_reg[QUO_BITS-2:0], 1'b1};
                    end else begin
                        quo_reg <= {quo_reg[QUO_BITS-2:0], 1'b0};
                    end
                    den_reg  <= den_reg >> 1;
                    dcnt_reg <= dcnt_reg - 1'b1;
                end
                ST_OUT: begin
                    m_tvalid_reg <= 1'b1;
                    chan_reg     <= cur_reg.chan;
                    low_reg      <= bnd_lo;
                    high_reg     <= bnd_hi;
                    last_reg     <= cur_reg.last;
                    if (vv < bnd_lo) pixel_reg <= 8'd0;
                    else if (vv > bnd_hi) pixel_reg <= 8'd255;
                    else if (bnd_hi == bnd_lo) pixel_reg <= 8'd0;
                    else pixel_reg <= quo_reg;
                    if (cur_reg.last) begin
                        total_reg <= '0;
                        addr_reg  <= '0;
                    end
                end
                default: ;
            endcase
        end
    end
endmodule
`default_nettype wire

/* src/percentile_contrast_stretch.sv */
// top level of the percentile contrast stretch
// two-pass contrast stretch: collect requests (tuser=0) build a per-channel
// histogram; the collect request with tlast runs a bound search that walks each
// channel's histogram bin by bin. map requests (tuser=1) pass through the pop,
// the 8-step divider and the output state; collect requests do a read-modify-
// write on the single histogram memory port. a result waiting on m_tready holds
// the back end, while the four-entry queue keeps taking requests until it is
// full. after reset and after the map request with tlast, a clearing pass sweeps
// all 2^18 histogram entries before requests are taken from the queue again.
`default_nettype none
module percentile_contrast_stretch import pcs_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,  // chan[1:0], sample[17:2], zero fill
    input  wire logic        s_tuser,  // req_type
    input  wire logic        s_tlast,  // last
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [47:0]      m_tdata,  // pixel_out, chan_out, low_used, high_used
    output logic             m_tlast,  // last_out
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_wdata
);
    logic [2:0]  chcnt_reg;
    logic [15:0] rlow_reg, rhigh_reg;
    logic        q_valid, q_pop;
    pcs_item_t   q_item;
    logic [7:0]  pixel_out;
    logic [1:0]  chan_out;
    logic [15:0] low_used, high_used;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            chcnt_reg <= 3'd1;
            rlow_reg  <= 16'd655;
            rhigh_reg <= 16'd655;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_CHANNEL_COUNT: chcnt_reg <= cfg_wdata[2:0];
                CFG_RATIO_LOW:     rlow_reg  <= cfg_wdata;
                CFG_RATIO_HIGH:    rhigh_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    pcs_front u_front (
        .aclk(aclk), .aresetn(aresetn), .s_tvalid(s_tvalid), .s_tready(s_tready),
        .req_type(s_tuser), .chan(s_tdata[1:0]), .sample(s_tdata[17:2]),
        .last(s_tlast), .channel_count(chcnt_reg),
        .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop)
    );

    pcs_back u_back (
        .aclk(aclk), .aresetn(aresetn), .q_valid(q_valid), .q_item(q_item),
        .q_pop(q_pop), .channel_count(chcnt_reg), .ratio_low(rlow_reg),
        .ratio_high(rhigh_reg), .m_tvalid(m_tvalid), .m_tready(m_tready),
        .pixel_out(pixel_out), .chan_out(chan_out), .low_used(low_used),
        .high_used(high_used), .last_out(m_tlast)
    );

    assign m_tdata = {6'd0, high_used, low_used, chan_out, pixel_out};
endmodule
`default_nettype wire

/* src/pcs_checker.sv */
// port-level checks for the contrast stretch
`default_nettype none
module pcs_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [47:0] m_tdata,
    input wire logic        m_tlast
);
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result dropped while stalled");
    a_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[47:42] == 6'd0)
        else $error("fill bits set");
    a_lowclip: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[25:10] == m_tdata[41:26]
        |-> m_tdata[7:0] == 8'd0 || m_tdata[7:0] == 8'd255)
        else $error("equal bounds must give a clipped value");
endmodule
bind percentile_contrast_stretch pcs_checker u_chk (.*);
`default_nettype wire

/* tb/percentile_contrast_stretch_test.sv */
// self-checking testbench for the percentile contrast stretch
`default_nettype none

class stretch_scoreboard;
    // mirrored block state
    int unsigned     hist [int unsigned];
    logic [15:0]     lo_bound [4];
    logic [15:0]     hi_bound [4];
    longint unsigned pix_total;
    logic [2:0]      chan_cfg;
    logic [15:0]     ratio_lo;
    logic [15:0]     ratio_hi;
    // expected results, packed as {last, high, low, chan, pixel}
    logic [42:0]     pending_pixels [$];
    int              errors;

    function new();
        for (int i = 0; i < 4; i++) begin
            lo_bound[i] = '0;
            hi_bound[i] = '0;
        end
        pix_total = 0;
        chan_cfg  = 3'd1;
        ratio_lo  = 16'd655;
        ratio_hi  = 16'd655;
        errors    = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [15:0] val);
        if (idx == pcs_pkg::CFG_CHANNEL_COUNT) chan_cfg = val[2:0];
        else if (idx == pcs_pkg::CFG_RATIO_LOW) ratio_lo = val;
        else if (idx == pcs_pkg::CFG_RATIO_HIGH) ratio_hi = val;
    endfunction

    function int unsigned active_chans();
        if (chan_cfg < 3'd1) return 1;
        if (chan_cfg > 3'd4) return 4;
        return 32'(chan_cfg);
    endfunction

    function longint unsigned bin_count(int unsigned idx);
        if (hist.exists(idx)) return 64'(hist[idx]);
        return 0;
    endfunction

    function longint unsigned sat32(longint unsigned s);
        return (s > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : s;
    endfunction

    function void search_bounds();
        longint unsigned thr_l, thr_h, run;
        int unsigned     nch, b;
        nch   = active_chans();
        thr_l = pix_total * 64'(ratio_lo);
        thr_h = pix_total * 64'(ratio_hi);
        for (int c = 0; c < 4; c++) begin
            lo_bound[c] = '0;
            hi_bound[c] = '0;
        end
        for (int unsigned c = 0; c < nch; c++) begin
            run = 0;
            for (b = 0; b < 65536; b++) begin
                run = sat32(run + bin_count(c * 65536 + b));
                if ((run << 16) > thr_l) begin
                    lo_bound[c] = 16'((b > 0) ? b - 1 : 0);
                    break;
                end
            end
            run = 0;
            for (b = 65536; b > 0; b--) begin
                run = sat32(run + bin_count(c * 65536 + b - 1));
                if ((run << 16) > thr_h) begin
                    hi_bound[c] = 16'((b - 1 < 65535) ? b : 65535);
                    break;
                end
            end
        end
    endfunction

    // called on every accepted request
    function void note_request(logic req, logic [1:0] chan, logic [15:0] v, logic last);
        int unsigned idx, lo, hi, px;
        if (req == pcs_pkg::REQ_COLLECT) begin
            if (32'(chan) < active_chans()) begin
                idx = 32'(chan) * 65536 + 32'(v);
                hist[idx] = 32'(sat32(bin_count(idx) + 1));
                if (chan == 2'd0) pix_total = sat32(pix_total + 1);
            end
            if (last) search_bounds();
        end else begin
            lo = 32'(lo_bound[chan]);
            hi = 32'(hi_bound[chan]);
            if (32'(v) < lo) px = 0;
            else if (32'(v) > hi) px = 255;
            else if (hi == lo) px = 0;
            else px = (255 * (32'(v) - lo)) / (hi - lo);
            pending_pixels.push_back({last, hi[15:0], lo[15:0], chan, px[7:0]});
            if (last) begin
                hist.delete();
                pix_total = 0;
            end
        end
    endfunction

    function void check_result(logic [47:0] data, logic last);
        logic [42:0] exp_r;
        if (pending_pixels.size() == 0) begin
            $display("%0t: unexpected result data=%h last=%b", $time, data, last);
            errors++;
            return;
        end
        exp_r = pending_pixels.pop_front();
        if (data[7:0] !== exp_r[7:0]) begin
            $display("%0t: pixel_out expected %0d actual %0d", $time, exp_r[7:0], data[7:0]);
            errors++;
        end
        if (data[9:8] !== exp_r[9:8]) begin
            $display("%0t: chan_out expected %0d actual %0d", $time, exp_r[9:8], data[9:8]);
            errors++;
        end
        if (data[25:10] !== exp_r[25:10]) begin
            $display("%0t: low_used expected %0d actual %0d", $time, exp_r[25:10],
                     data[25:10]);
            errors++;
        end
        if (data[41:26] !== exp_r[41:26]) begin
            $display("%0t: high_used expected %0d actual %0d", $time, exp_r[41:26],
                     data[41:26]);
            errors++;
        end
        if (last !== exp_r[42]) begin
            $display("%0t: last_out expected %b actual %b", $time, exp_r[42], last);
            errors++;
        end
    endfunction
endclass

module percentile_contrast_stretch_test;
    import pcs_pkg::*;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;   // chan[1:0], sample[17:2], zero fill
    logic        s_tuser = 1'b0; // req_type
    logic        s_tlast = 1'b0; // last
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;        // pixel_out, chan_out, low_used, high_used
    logic        m_tlast;        // last_out
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [15:0] cfg_wdata = '0;

    stretch_scoreboard sb = new();

    // idling is switched off for the closing stretch
    bit quiet = 1'b0;
    // long receiver hold-off requested by the stimulus, in cycles
    int rx_hold_req = 0;

    always #1 aclk = ~aclk;

    percentile_contrast_stretch u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .s_tuser(s_tuser), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    // results are checked at the rising edge on which they are taken
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata, m_tlast);
    end

    // receiver: random stall bursts, plus the long hold-off on request
    initial begin
        int stall_left;
        stall_left = 0;
        forever begin
            @(negedge aclk);
            if (rx_hold_req > 0) begin
                stall_left  = rx_hold_req;
                rx_hold_req = 0;
            end
            if (stall_left > 0) begin
                m_tready = 1'b0;
                stall_left--;
            end else if (!quiet && $urandom_range(0, 11) == 0) begin
                m_tready   = 1'b0;
                stall_left = int'($urandom_range(1, 18)) - 1;
            end else begin
                m_tready = 1'b1;
            end
        end
    end

    // hard stop in case the block hangs
    initial begin
        #200000000;
        $display("FAILURE");
        $finish;
    end

    // register write at the falling edge, block must be idle
    task automatic write_reg(logic [1:0] idx, logic [15:0] val);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_wdata = val;
        sb.write_reg(idx, val);
        @(negedge aclk);
        cfg_we = 1'b0;
    endtask

    task automatic set_config(logic [15:0] nch, logic [15:0] rlo, logic [15:0] rhi);
        write_reg(CFG_CHANNEL_COUNT, nch);
        write_reg(CFG_RATIO_LOW, rlo);
        write_reg(CFG_RATIO_HIGH, rhi);
    endtask

    // offer one request and hold it until the block takes it
    task automatic send_request(logic req, logic [1:0] chan, logic [15:0] v, logic last);
        if (!quiet && $urandom_range(0, 9) == 0) begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tuser  = req;
        s_tdata  = {6'b0, v, chan};
        s_tlast  = last;
        forever begin
            @(posedge aclk);
            if (s_tready) break;
        end
        sb.note_request(req, chan, v, last);
        @(negedge aclk);
        s_tvalid = 1'b0;
    endtask

    // sender pause until every expected result has come
    task automatic wait_drained();
        s_tvalid = 1'b0;
        while (sb.pending_pixels.size() != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    // collect values lean to the ends of the range so the bound walks stay short
    function automatic logic [15:0] collect_value();
        case ($urandom_range(0, 3))
            0: return 16'($urandom_range(0, 255));
            1: return 16'($urandom_range(65280, 65535));
            2: return 16'($urandom_range(0, 2047));
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    // one image: collect rounds each ending in a search, then map requests
    task automatic run_image(int rounds, int n_col, int n_map, bit end_image, bit hold);
        for (int r = 0; r < rounds; r++) begin
            for (int i = 0; i < n_col; i++) begin
                // the odd map request mixed into the collect stream
                if ($urandom_range(0, 19) == 0)
                    send_request(REQ_MAP, 2'($urandom_range(0, 3)),
                                 16'($urandom_range(0, 65535)), 1'b0);
                send_request(REQ_COLLECT, 2'($urandom_range(0, 3)), collect_value(),
                             i == n_col - 1);
            end
            for (int i = 0; i < n_map; i++) begin
                // by now the search is over, so the hold-off fills the block
                if (hold && r == 0 && i == 5) rx_hold_req = 3000;
                send_request(REQ_MAP, 2'($urandom_range(0, 3)), 16'($urandom_range(0, 65535)),
                             end_image && r == rounds - 1 && i == n_map - 1);
            end
            wait_drained();
        end
    endtask

    initial begin
        repeat (10) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // reset values, then map before any search uses bounds (0,0)
        set_config(16'd1, 16'd655, 16'd655);
        send_request(REQ_MAP, 2'd0, 16'd0, 1'b0);
        send_request(REQ_MAP, 2'd3, 16'd65535, 1'b0);
        send_request(REQ_MAP, 2'd1, 16'd1, 1'b0);

        // small image, extremes of the sample field, inactive channel ignored
        send_request(REQ_COLLECT, 2'd0, 16'd0, 1'b0);
        send_request(REQ_COLLECT, 2'd0, 16'd1, 1'b0);
        send_request(REQ_COLLECT, 2'd0, 16'd65535, 1'b0);
        send_request(REQ_COLLECT, 2'd0, 16'd65534, 1'b0);
        send_request(REQ_COLLECT, 2'd2, 16'd300, 1'b0);
        send_request(REQ_COLLECT, 2'd0, 16'h5555, 1'b0);
        send_request(REQ_COLLECT, 2'd0, 16'hAAAA, 1'b1);
        send_request(REQ_MAP, 2'd0, 16'd0, 1'b0);
        send_request(REQ_MAP, 2'd0, 16'h5555, 1'b0);
        send_request(REQ_MAP, 2'd0, 16'hAAAA, 1'b0);
        send_request(REQ_MAP, 2'd0, 16'd65535, 1'b0);
        send_request(REQ_MAP, 2'd2, 16'd300, 1'b0);
        // collect after a search keeps accumulating
        send_request(REQ_COLLECT, 2'd0, 16'd2, 1'b0);
        send_request(REQ_COLLECT, 2'd0, 16'd65533, 1'b1);
        send_request(REQ_MAP, 2'd0, 16'd3, 1'b0);
        send_request(REQ_MAP, 2'd0, 16'd65535, 1'b1);
        wait_drained();

        // empty histogram, threshold never met, bounds stay 0
        send_request(REQ_COLLECT, 2'd1, 16'd7, 1'b1);
        send_request(REQ_MAP, 2'd0, 16'd0, 1'b0);
        send_request(REQ_MAP, 2'd0, 16'd9, 1'b0);
        wait_drained();

        // channel count 0 acts as 1, zero ratios stop each walk at the first filled bin
        set_config(16'd0, 16'd0, 16'd0);
        run_image(2, 40, 40, 1'b0, 1'b0);

        // channel count above the maximum, mixed ratios, long receiver hold-off
        set_config(16'd7, 16'd0, 16'd1000);
        run_image(2, 40, 60, 1'b1, 1'b1);

        set_config(16'd4, 16'($urandom_range(0, 4000)), 16'($urandom_range(0, 4000)));
        run_image(2, 40, 40, 1'b0, 1'b0);

        // full ratio on one side
        set_config(16'd1, 16'd65535, 16'd0);
        run_image(1, 40, 40, 1'b0, 1'b0);

        set_config(16'd3, 16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
        run_image(2, 40, 40, 1'b0, 1'b0);

        set_config(16'd2, 16'd0, 16'd65535);
        run_image(1, 40, 40, 1'b0, 1'b0);

        // closing stretch with no idling on either side
        quiet = 1'b1;
        set_config(16'd5, 16'($urandom_range(0, 2000)), 16'($urandom_range(0, 2000)));
        run_image(1, 40, 120, 1'b1, 1'b0);

        wait_drained();
        repeat (100) @(negedge aclk);
        if (sb.errors == 0 && sb.pending_pixels.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule

`default_nettype wire
